// File: sv/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants for the Lua comment stripper
// Character codes, scanner modes and the per-request emission plan.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_RBR  = 8'h5D;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_NUL  = 8'h00;

  typedef enum logic [6:0] {
    MODE_NORMAL = 7'b0000001,
    MODE_DASH1  = 7'b0000010,
    MODE_DASH2  = 7'b0000100,
    MODE_OPEN   = 7'b0001000,
    MODE_LINE   = 7'b0010000,
    MODE_LONG   = 7'b0100000,
    MODE_CLOSE  = 7'b1000000
  } mode_e;

  // Fixed part of the emission plan; the space count travels beside it.
  typedef struct packed {
    logic       head_vld;
    logic [7:0] head;
    logic       tail_vld;
    logic [7:0] tail;
    logic       last;
    logic       ovf;
    logic       bare;
  } plan_t;

endpackage

// File: sv/lcs_if.sv
// ----------------------------------------------------------------------------
// lcs_if: stream channels of the Lua comment stripper
// Input byte channel and output result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface lcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;
  logic       level_overflow;

  modport source (output valid, output out_byte, output byte_valid, output out_last,
                  output level_overflow, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input out_last,
                input level_overflow, output ready);
endinterface

// File: sv/lcs_scanner.sv
// ----------------------------------------------------------------------------
// lcs_scanner: comment recognizer
// Holds the scan mode and bracket levels and turns each accepted byte into
// an emission plan: optional head byte, a run of spaces, optional tail byte.
// ----------------------------------------------------------------------------
module lcs_scanner #(
  parameter int MAX_LEVEL = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [7:0]                          byte_i,
  input  logic                                last_i,
  output lcs_pkg::plan_t                      plan_o,
  output logic [$clog2(MAX_LEVEL + 5) - 1:0]  nsp_o
);

  localparam int PW = $clog2(MAX_LEVEL + 1);
  localparam int CW = $clog2(MAX_LEVEL + 5);
  localparam logic [PW-1:0] MaxPe = PW'(MAX_LEVEL);

  lcs_pkg::mode_e mode_q, mode_d, mode_s;
  logic [PW-1:0]  lvl_q, lvl_d, pe_q, pe_d;
  logic [7:0]     body;
  lcs_pkg::plan_t plan;
  logic [CW-1:0]  nsp;

  always_comb begin
    body = ((byte_i == lcs_pkg::CH_NL) || (byte_i == lcs_pkg::CH_CR)) ? byte_i
                                                                      : lcs_pkg::CH_SP;
    mode_s        = mode_q;
    lvl_d         = lvl_q;
    pe_d          = pe_q;
    nsp           = '0;
    plan.head_vld = 1'b0;
    plan.head     = lcs_pkg::CH_DASH;
    plan.tail_vld = 1'b0;
    plan.tail     = byte_i;
    plan.last     = last_i;
    plan.ovf      = 1'b0;
    plan.bare     = 1'b0;

    unique case (mode_q)
      lcs_pkg::MODE_DASH1: begin
        if (byte_i == lcs_pkg::CH_DASH) begin
          mode_s = lcs_pkg::MODE_DASH2;
        end else begin
          plan.head_vld = 1'b1;
          plan.tail_vld = 1'b1;
          mode_s        = lcs_pkg::MODE_NORMAL;
        end
      end
      lcs_pkg::MODE_DASH2: begin
        if (byte_i == lcs_pkg::CH_LBR) begin
          mode_s = lcs_pkg::MODE_OPEN;
          pe_d   = '0;
        end else begin
          nsp           = CW'(2);
          plan.tail_vld = 1'b1;
          plan.tail     = body;
          mode_s        = (byte_i == lcs_pkg::CH_NL) ? lcs_pkg::MODE_NORMAL
                                                     : lcs_pkg::MODE_LINE;
        end
      end
      lcs_pkg::MODE_OPEN: begin
        if (byte_i == lcs_pkg::CH_EQ) begin
          if (pe_q >= MaxPe) begin
            // The equals run is too long to be a bracket: fall back to a line comment.
            plan.ovf = 1'b1;
            nsp      = CW'(pe_q) + CW'(4);
            pe_d     = '0;
            mode_s   = lcs_pkg::MODE_LINE;
          end else begin
            pe_d = pe_q + PW'(1);
          end
        end else if (byte_i == lcs_pkg::CH_LBR) begin
          lvl_d  = pe_q;
          pe_d   = '0;
          mode_s = lcs_pkg::MODE_LONG;
        end else begin
          nsp           = CW'(pe_q) + CW'(3);
          pe_d          = '0;
          plan.tail_vld = 1'b1;
          plan.tail     = body;
          mode_s        = (byte_i == lcs_pkg::CH_NL) ? lcs_pkg::MODE_NORMAL
                                                     : lcs_pkg::MODE_LINE;
        end
      end
      lcs_pkg::MODE_LINE: begin
        plan.tail_vld = 1'b1;
        plan.tail     = body;
        if (byte_i == lcs_pkg::CH_NL) begin
          mode_s = lcs_pkg::MODE_NORMAL;
        end
      end
      lcs_pkg::MODE_LONG: begin
        if (byte_i == lcs_pkg::CH_RBR) begin
          mode_s = lcs_pkg::MODE_CLOSE;
          pe_d   = '0;
        end else begin
          plan.tail_vld = 1'b1;
          plan.tail     = body;
        end
      end
      lcs_pkg::MODE_CLOSE: begin
        if (byte_i == lcs_pkg::CH_EQ) begin
          if (pe_q >= lvl_q) begin
            nsp    = CW'(pe_q) + CW'(2);
            pe_d   = '0;
            mode_s = lcs_pkg::MODE_LONG;
          end else begin
            pe_d = pe_q + PW'(1);
          end
        end else if (byte_i == lcs_pkg::CH_RBR) begin
          if (pe_q == lvl_q) begin
            mode_s = lcs_pkg::MODE_NORMAL;
            lvl_d  = '0;
          end else begin
            // A failed closer; this bracket may start the next attempt.
            nsp = CW'(pe_q) + CW'(1);
          end
          pe_d = '0;
        end else begin
          nsp           = CW'(pe_q) + CW'(1);
          pe_d          = '0;
          mode_s        = lcs_pkg::MODE_LONG;
          plan.tail_vld = 1'b1;
          plan.tail     = body;
        end
      end
      default: begin
        mode_s = lcs_pkg::MODE_NORMAL;
        if (byte_i == lcs_pkg::CH_DASH) begin
          mode_s = lcs_pkg::MODE_DASH1;
        end else begin
          plan.tail_vld = 1'b1;
        end
      end
    endcase

    mode_d = mode_s;
    if (last_i) begin
      // Flush the pending lookahead. None of these modes has emitted anything yet
      // in this request except a failed closer, whose spaces simply add up.
      case (mode_s)
        lcs_pkg::MODE_DASH1: plan.head_vld = 1'b1;
        lcs_pkg::MODE_DASH2: nsp = CW'(2);
        lcs_pkg::MODE_OPEN:  nsp = CW'(pe_d) + CW'(3);
        lcs_pkg::MODE_CLOSE: nsp = nsp + CW'(pe_d) + CW'(1);
        default: ;
      endcase
      mode_d    = lcs_pkg::MODE_NORMAL;
      lvl_d     = '0;
      pe_d      = '0;
      plan.bare = !plan.head_vld && (nsp == '0) && !plan.tail_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lcs_pkg::MODE_NORMAL;
      lvl_q  <= '0;
      pe_q   <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      lvl_q  <= lvl_d;
      pe_q   <= pe_d;
    end
  end

  assign plan_o = plan;
  assign nsp_o  = nsp;

endmodule

// File: sv/lcs_emitter.sv
// ----------------------------------------------------------------------------
// lcs_emitter: result sequencer
// Holds the plan of the current request and sends one result per cycle into
// the output register while it is not stalled; frees the plan slot as the last result leaves.
// ----------------------------------------------------------------------------
module lcs_emitter #(
  parameter int MAX_LEVEL = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  lcs_pkg::plan_t                      plan_i,
  input  logic [$clog2(MAX_LEVEL + 5) - 1:0]  nsp_i,
  output logic                                ready_o,
  lcs_out_if.source                           out_o
);

  localparam int CW = $clog2(MAX_LEVEL + 5);

  lcs_pkg::plan_t plan_q, plan_d, after;
  logic [CW-1:0]  cnt_q, cnt_d, cnt_after;
  logic           cur_empty, after_empty, pick;
  logic [7:0]     pick_byte;
  logic           out_vld_q;
  logic [7:0]     out_byte_q;
  logic           byte_vld_q, out_last_q, ovf_q;

  always_comb begin
    cur_empty = !plan_q.head_vld && (cnt_q == '0) && !plan_q.tail_vld && !plan_q.bare;
    pick      = (!out_vld_q || out_o.ready) && !cur_empty;
    after     = plan_q;
    cnt_after = cnt_q;
    pick_byte = lcs_pkg::CH_NUL;
    // Order within a request: head byte, spaces, tail byte, or a bare end marker.
    if (plan_q.head_vld) begin
      after.head_vld = 1'b0;
      pick_byte      = plan_q.head;
    end else if (cnt_q != '0) begin
      cnt_after = cnt_q - CW'(1);
      pick_byte = lcs_pkg::CH_SP;
    end else if (plan_q.tail_vld) begin
      after.tail_vld = 1'b0;
      pick_byte      = plan_q.tail;
    end else begin
      after.bare = 1'b0;
    end
    after_empty = !after.head_vld && (cnt_after == '0) && !after.tail_vld && !after.bare;
    ready_o     = cur_empty || (pick && after_empty);

    if (accept_i) begin
      plan_d = plan_i;
      cnt_d  = nsp_i;
    end else if (pick) begin
      plan_d = after;
      cnt_d  = cnt_after;
    end else begin
      plan_d = plan_q;
      cnt_d  = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_q    <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      plan_q <= plan_d;
      cnt_q  <= cnt_d;
      if (pick) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pick) begin
      out_byte_q <= pick_byte;
      byte_vld_q <= !plan_q.bare || plan_q.head_vld || (cnt_q != '0) || plan_q.tail_vld;
      out_last_q <= plan_q.last && after_empty;
      ovf_q      <= plan_q.ovf;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.out_byte       = out_byte_q;
  assign out_o.byte_valid     = byte_vld_q;
  assign out_o.out_last       = out_last_q;
  assign out_o.level_overflow = ovf_q;

endmodule

// File: sv/lua_comment_stripper.sv
// An accepted byte's plan is registered in the emitter's plan slot and each
// result in the output register. Throughput: one byte per cycle while each byte
// yields at most one result and the output is not stalled; a byte with more
// results (at most MAX_LEVEL + 4) holds the input until its last is registered.
// Reset: asynchronous, active low; returns to normal text with no pending lookahead.
// ----------------------------------------------------------------------------
// lua_comment_stripper: top level
// Blanks Lua line and long comments in a byte stream, keeping line structure.
// ----------------------------------------------------------------------------
module lua_comment_stripper #(
  parameter int MAX_LEVEL = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lcs_in_if.sink    in_i,
  lcs_out_if.source out_o
);

  localparam int CW = $clog2(MAX_LEVEL + 5);

  lcs_pkg::plan_t plan;
  logic [CW-1:0]  nsp;
  logic           ready;
  logic           accept;

  assign in_i.ready = ready;
  assign accept     = in_i.valid && ready;

  lcs_scanner #(
    .MAX_LEVEL (MAX_LEVEL)
  ) u_scanner (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_i.in_byte),
    .last_i   (in_i.in_last),
    .plan_o   (plan),
    .nsp_o    (nsp)
  );

  lcs_emitter #(
    .MAX_LEVEL (MAX_LEVEL)
  ) u_emitter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .plan_i   (plan),
    .nsp_i    (nsp),
    .ready_o  (ready),
    .out_o    (out_o)
  );

endmodule
